// ===== rtl/tkcm_pkg.sv =====
package tkcm_pkg;

    localparam int PDIG_W = 64;   // pattern register, one 4-bit symbol per nibble
    localparam int PLEN_W = 5;    // pattern length register
    localparam int SYM_W  = 4;
    localparam int LLEN_W = 7;    // line length counters, saturating
    localparam int CNT_W  = 16;   // matched record counter
    localparam int DATA_W = 64;   // APB data bus
    localparam int ADDR_W = 4;    // registers at byte offsets 0 and 8

    localparam logic [SYM_W-1:0] SYM_PLUS = 4'd10;
    localparam logic [SYM_W-1:0] SYM_NONE = 4'd15;

    localparam logic [LLEN_W-1:0] LEN_SAT = 7'd127;
    localparam logic [CNT_W-1:0]  CNT_SAT = 16'hFFFF;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic OP_NAME   = 1'b0;
    localparam logic OP_NUMBER = 1'b1;

    localparam logic REG_PATTERN_DIGITS = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic [PDIG_W-1:0] digits;
        logic [PLEN_W-1:0] eff_len;   // already clipped to the pattern capacity
    } t_cfg;

    // Keypad digit of a name character; anything that is not a digit, a letter
    // or a plus sign gets the symbol that matches nothing.
    function automatic logic [SYM_W-1:0] keypad_symbol(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] l;
        logic [SYM_W-1:0] s;
        diff = 8'd0;
        l    = 5'd0;
        s    = SYM_NONE;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            diff = c - CH_ZERO;
            s    = diff[SYM_W-1:0];
        end else if (c == CH_PLUS) begin
            s = 4'd0;
        end else if (c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]}) begin
            diff = (c >= CH_LO_A) ? (c - CH_LO_A) : (c - CH_UP_A);
            l    = diff[4:0];
            if (l < 5'd3)       s = 4'd2;
            else if (l < 5'd6)  s = 4'd3;
            else if (l < 5'd9)  s = 4'd4;
            else if (l < 5'd12) s = 4'd5;
            else if (l < 5'd15) s = 4'd6;
            else if (l < 5'd19) s = 4'd7;
            else if (l < 5'd22) s = 4'd8;
            else                s = 4'd9;
        end
        return s;
    endfunction

endpackage

// ===== rtl/t9_keypad_contact_matcher_core.sv =====
// Keypad contact matcher.
// Contact records arrive on the input channel one character per word: the
// name line (i_op = 0) and then the number line (i_op = 1). A word with
// i_has_char low carries no character and is how an empty line is sent;
// i_last_of_line marks the final word of a line. Name letters are read as
// their phone keypad digits and a shift-and search looks for the pattern in
// the mapped name, the raw number and the number with '+' read as 0.
// Only the last word of a number line produces a result word: record_valid,
// record_matched and the saturating count of matched records. All other
// words update the per-record state and produce nothing.
// The last word of a number line passes through the input register and then
// the result register before its result word appears on the output. One word
// is accepted per cycle while no result word is held by a stalled receiver:
// the search update for one character is a single pass of logic between the
// input register and the state registers.
// When the receiver stalls, the result register holds its word, the input
// register can still take one more word, and words that produce no result
// keep flowing. Reset clears the pattern registers, the per-record state and
// the match counter. The user must write the pattern (APB port, offset 0:
// 64-bit symbols, offset 8: length) with no record in flight; unenforced.
module t9_keypad_contact_matcher_core #(
    parameter int PATTERN_MAX = 16,
    parameter int LINE_MAX    = 100
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [7:0]                      i_ch,
    input  logic                            i_has_char,
    input  logic                            i_last_of_line,
    // result words
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_record_valid,
    output logic                            o_record_matched,
    output logic [tkcm_pkg::CNT_W-1:0]      o_match_count,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tkcm_pkg::ADDR_W-1:0]     paddr,
    input  logic [tkcm_pkg::DATA_W-1:0]     pwdata,
    output logic [tkcm_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    tkcm_pkg::t_cfg cfg;

    tkcm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register.
    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_ch;
    logic       r_has_char;
    logic       r_last;

    // Per-record search state and the running count.
    logic [PATTERN_MAX-1:0]          r_name_vec, n_name_vec;
    logic [PATTERN_MAX-1:0]          r_raw_vec, n_raw_vec;
    logic [PATTERN_MAX-1:0]          r_pz_vec, n_pz_vec;
    logic                            r_hit, n_hit;
    logic [tkcm_pkg::LLEN_W-1:0]     r_name_len, n_name_len;
    logic [tkcm_pkg::LLEN_W-1:0]     r_num_len, n_num_len;
    logic                            r_num_bad, n_num_bad;
    logic [tkcm_pkg::CNT_W-1:0]      r_found, n_found;

    // Result register.
    logic                            r_out_valid;
    logic                            r_rec_valid, n_rec_valid;
    logic                            r_rec_matched, n_rec_matched;
    logic [tkcm_pkg::CNT_W-1:0]      r_count;

    logic                            emit;
    logic                            adv;
    logic                            in_acc;

    // Symbols of the current character for the three streams.
    logic [tkcm_pkg::SYM_W-1:0]      sym_name, sym_raw, sym_pz;
    logic [7:0]                      digit_val;
    logic                            is_digit;
    logic                            plus_bad, char_bad;
    logic [PATTERN_MAX-1:0]          adv_name_vec, adv_raw_vec, adv_pz_vec;
    logic                            hit_name, hit_raw, hit_pz;
    logic                            do_name, do_num;

    // A word moves out of the input register unless it produces a result and
    // the result register is still holding an earlier one.
    assign emit    = (r_op == tkcm_pkg::OP_NUMBER) && r_last;
    assign adv     = r_in_valid && (!emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_op;
            r_ch       <= i_ch;
            r_has_char <= i_has_char;
            r_last     <= i_last_of_line;
        end
    end

    assign is_digit  = (r_ch >= tkcm_pkg::CH_ZERO) && (r_ch <= tkcm_pkg::CH_NINE);
    assign digit_val = r_ch - tkcm_pkg::CH_ZERO;
    assign sym_name  = tkcm_pkg::keypad_symbol(r_ch);

    always_comb begin
        if (is_digit) begin
            sym_raw = digit_val[tkcm_pkg::SYM_W-1:0];
            sym_pz  = digit_val[tkcm_pkg::SYM_W-1:0];
        end else if (r_ch == tkcm_pkg::CH_PLUS) begin
            sym_raw = tkcm_pkg::SYM_PLUS;
            sym_pz  = '0;
        end else begin
            sym_raw = tkcm_pkg::SYM_NONE;
            sym_pz  = tkcm_pkg::SYM_NONE;
        end
    end

    // A plus sign is only allowed as the first character of the number.
    assign plus_bad = (r_ch == tkcm_pkg::CH_PLUS) && (r_num_len != '0);
    assign char_bad = !is_digit && (r_ch != tkcm_pkg::CH_PLUS)
                   && (r_ch != tkcm_pkg::CH_SPACE);

    tkcm_shift_and #(.PATTERN_MAX(PATTERN_MAX)) u_sa_name (
        .i_vec (r_name_vec),
        .i_sym (sym_name),
        .i_cfg (cfg),
        .o_vec (adv_name_vec),
        .o_hit (hit_name)
    );

    tkcm_shift_and #(.PATTERN_MAX(PATTERN_MAX)) u_sa_raw (
        .i_vec (r_raw_vec),
        .i_sym (sym_raw),
        .i_cfg (cfg),
        .o_vec (adv_raw_vec),
        .o_hit (hit_raw)
    );

    tkcm_shift_and #(.PATTERN_MAX(PATTERN_MAX)) u_sa_pz (
        .i_vec (r_pz_vec),
        .i_sym (sym_pz),
        .i_cfg (cfg),
        .o_vec (adv_pz_vec),
        .o_hit (hit_pz)
    );

    assign do_name = r_has_char && (r_op == tkcm_pkg::OP_NAME);
    assign do_num  = r_has_char && (r_op == tkcm_pkg::OP_NUMBER);

    // Next record state including the current character, then the verdict
    // taken from that updated state on the last word of the number line.
    always_comb begin
        n_name_vec = do_name ? adv_name_vec : r_name_vec;
        n_raw_vec  = do_num  ? adv_raw_vec  : r_raw_vec;
        n_pz_vec   = do_num  ? adv_pz_vec   : r_pz_vec;
        n_hit      = r_hit || (do_name && hit_name) || (do_num && (hit_raw || hit_pz));
        n_name_len = (do_name && (r_name_len != tkcm_pkg::LEN_SAT))
                   ? r_name_len + 1'b1 : r_name_len;
        n_num_len  = (do_num && (r_num_len != tkcm_pkg::LEN_SAT))
                   ? r_num_len + 1'b1 : r_num_len;
        n_num_bad  = r_num_bad || (do_num && (plus_bad || char_bad));

        n_rec_valid   = !n_num_bad
                     && (n_name_len <= tkcm_pkg::LLEN_W'(LINE_MAX))
                     && (n_num_len  <= tkcm_pkg::LLEN_W'(LINE_MAX));
        n_rec_matched = n_rec_valid && ((cfg.eff_len == '0) || n_hit);
        n_found       = (emit && n_rec_matched && (r_found != tkcm_pkg::CNT_SAT))
                      ? r_found + 1'b1 : r_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_vec <= '0;
            r_raw_vec  <= '0;
            r_pz_vec   <= '0;
            r_hit      <= 1'b0;
            r_name_len <= '0;
            r_num_len  <= '0;
            r_num_bad  <= 1'b0;
            r_found    <= '0;
        end else if (adv) begin
            r_found <= n_found;
            if (emit) begin
                // The record is closed: start the next one from scratch.
                r_name_vec <= '0;
                r_raw_vec  <= '0;
                r_pz_vec   <= '0;
                r_hit      <= 1'b0;
                r_name_len <= '0;
                r_num_len  <= '0;
                r_num_bad  <= 1'b0;
            end else begin
                r_name_vec <= n_name_vec;
                r_raw_vec  <= n_raw_vec;
                r_pz_vec   <= n_pz_vec;
                r_hit      <= n_hit;
                r_name_len <= n_name_len;
                r_num_len  <= n_num_len;
                r_num_bad  <= n_num_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_rec_valid   <= n_rec_valid;
            r_rec_matched <= n_rec_matched;
            r_count       <= n_found;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_record_valid   = r_rec_valid;
    assign o_record_matched = r_rec_matched;
    assign o_match_count    = r_count;

    // A matched record is always a valid one.
    a_match_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_rec_matched || r_rec_valid))
        else $error("matched record reported as invalid");

    // The matched record counter never moves backwards.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_found >= $past(r_found)))
        else $error("match counter decreased");

    // A word held in the input register is not dropped while it waits.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("stalled input word lost");

    // Closing a record clears its hit and error flags and both line lengths.
    a_record_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit) |=> (!r_hit && !r_num_bad && (r_name_len == '0)
                           && (r_num_len == '0)))
        else $error("record state not cleared after result");

endmodule

// ===== rtl/tkcm_cfg.sv =====
module tkcm_cfg #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tkcm_pkg::ADDR_W-1:0]      paddr,
    input  logic [tkcm_pkg::DATA_W-1:0]      pwdata,
    output logic [tkcm_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output tkcm_pkg::t_cfg                   o_cfg
);

    logic [tkcm_pkg::PDIG_W-1:0] r_digits;
    logic [tkcm_pkg::PLEN_W-1:0] r_length;
    logic                        wr_en;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers sit on 8-byte boundaries; the offset within a word is ignored.
    assign reg_sel = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '0;
            r_length <= '0;
        end else if (wr_en) begin
            if (reg_sel == tkcm_pkg::REG_PATTERN_DIGITS) begin
                r_digits <= pwdata[tkcm_pkg::PDIG_W-1:0];
            end else begin
                r_length <= pwdata[tkcm_pkg::PLEN_W-1:0];
            end
        end
    end

    always_comb begin
        case (reg_sel)
            tkcm_pkg::REG_PATTERN_DIGITS: prdata = r_digits;
            tkcm_pkg::REG_PATTERN_LENGTH:
                prdata = {{(tkcm_pkg::DATA_W-tkcm_pkg::PLEN_W){1'b0}}, r_length};
            default: prdata = '0;
        endcase
    end

    // A length beyond the pattern capacity behaves as the full capacity.
    assign o_cfg.digits  = r_digits;
    assign o_cfg.eff_len = (r_length > tkcm_pkg::PLEN_W'(PATTERN_MAX))
                         ? tkcm_pkg::PLEN_W'(PATTERN_MAX) : r_length;

endmodule

// ===== rtl/tkcm_shift_and.sv =====
module tkcm_shift_and #(
    parameter int PATTERN_MAX = 16
) (
    input  logic [PATTERN_MAX-1:0]        i_vec,
    input  logic [tkcm_pkg::SYM_W-1:0]    i_sym,
    input  tkcm_pkg::t_cfg                i_cfg,
    output logic [PATTERN_MAX-1:0]        o_vec,
    output logic                          o_hit
);

    logic [PATTERN_MAX-1:0] mask;
    logic [PATTERN_MAX:0]   shifted;

    // One bit per pattern position: set where the symbol equals that position.
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            mask[k] = (i_sym != tkcm_pkg::SYM_NONE)
                   && (i_cfg.digits[4*k +: 4] == i_sym)
                   && (k < int'(i_cfg.eff_len));
        end
    end

    assign shifted = {i_vec, 1'b1};
    assign o_vec   = shifted[PATTERN_MAX-1:0] & mask;

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (o_vec[k] && (int'(i_cfg.eff_len) == k + 1)) o_hit = 1'b1;
        end
    end

endmodule
